FILE: rtl/hdc_pkg.sv
// Shared types and constants for the heater duty controller.
// No dependencies; imported by every module of the block.
package hdc_pkg;

   localparam int TEMP_W     = 16;
   localparam int OFFSET_W   = 13;
   localparam int RAMP_W     = 12;
   localparam int DUTY_W     = 8;
   localparam int MODE_W     = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int ERR_W      = 16;
   localparam int PROD_W     = ERR_W + DUTY_W;
   localparam int DIV_STEPS  = PROD_W;
   localparam int CNT_W      = $clog2(DIV_STEPS);

   localparam logic signed [TEMP_W-1:0] COLD_LIMIT = -16'sd800;

   localparam logic [MODE_W-1:0] MODE_OFF    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_FIXED  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_DEW    = 2'd2;
   localparam logic [MODE_W-1:0] MODE_TARGET = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_MODE       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DUTY   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_DUTY   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DEW_OFFSET = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_RAMP_BAND  = 3'd5;

   typedef enum logic [1:0] {
      LVL_ZERO,
      LVL_MAX,
      LVL_RAMP
   } level_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_MUL,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                     temp_valid;
      logic signed [TEMP_W-1:0] heater_temp;
      logic                     dew_valid;
      logic signed [TEMP_W-1:0] dew_point;
   } req_type;

   typedef struct packed {
      logic [DUTY_W-1:0] pwm_level;
      logic              pwm_changed;
      logic [MODE_W-1:0] mode_now;
      logic              forced_off;
   } rsp_type;

   typedef struct packed {
      logic load_req;
      logic prep;
      logic mult;
      logic div_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

endpackage

FILE: rtl/hdc_ctrl.sv
// Sequencer for the heater duty controller: request capture, decision,
// multiply, serial divide and result load. Depends on hdc_pkg.
module hdc_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  hdc_pkg::status_type status,
   output hdc_pkg::cmd_type    cmd
);
   import hdc_pkg::*;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mult = 1'b1;
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: rtl/hdc_dp.sv
// Datapath for the heater duty controller: control registers, mode and
// sensor decision, multiplier, restoring divider, clamp and output register.
// Depends on hdc_pkg.
module hdc_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_en,
   input  logic [hdc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [hdc_pkg::CSR_DATA_W-1:0]    csr_write_data,
   input  hdc_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output hdc_pkg::rsp_type                  rsp_data,
   input  hdc_pkg::cmd_type                  cmd,
   output hdc_pkg::status_type               status
);
   import hdc_pkg::*;

   // control registers
   logic [MODE_W-1:0]          mode_req_ff;
   logic [DUTY_W-1:0]          max_duty_ff;
   logic [DUTY_W-1:0]          min_duty_ff;
   logic signed [TEMP_W-1:0]   target_ff;
   logic signed [OFFSET_W-1:0] dew_offset_ff;
   logic [RAMP_W-1:0]          ramp_ff;

   logic                       latch_ff, latch_in;
   logic [DUTY_W-1:0]          last_level_ff;
   req_type                    req_ff;

   level_kind_type             kind_ff, kind_in;
   logic [MODE_W-1:0]          mode_now_ff, mode_now_in;
   logic [ERR_W-1:0]           err_ff, err_in;
   logic                       span_neg_ff, span_neg_in;
   logic [DUTY_W-1:0]          span_mag_ff, span_mag_in;

   logic [PROD_W-1:0]          quot_ff, quot_in;
   logic [RAMP_W-1:0]          rem_ff, rem_in;

   logic                       rsp_valid_ff;
   rsp_type                    rsp_ff, rsp_in;

   // decision signals
   logic [MODE_W-1:0]          mode_eff;
   logic                       t_ok;
   logic                       missing;
   logic signed [TEMP_W:0]     target_sel;
   logic signed [TEMP_W:0]     temp_x;
   logic signed [TEMP_W+1:0]   err_full;

   // divider signals
   logic [RAMP_W:0]            shifted;

   // level signals
   logic signed [PROD_W+1:0]   q_signed;
   logic signed [PROD_W+1:0]   sum;
   logic [DUTY_W-1:0]          ramp_level;
   logic [DUTY_W-1:0]          level;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_req_ff   <= MODE_OFF;
         max_duty_ff   <= '0;
         min_duty_ff   <= '0;
         target_ff     <= '0;
         dew_offset_ff <= '0;
         ramp_ff       <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_MODE:       mode_req_ff   <= csr_write_data[MODE_W-1:0];
            CSR_MAX_DUTY:   max_duty_ff   <= csr_write_data[DUTY_W-1:0];
            CSR_MIN_DUTY:   min_duty_ff   <= csr_write_data[DUTY_W-1:0];
            CSR_TARGET:     target_ff     <= $signed(csr_write_data[TEMP_W-1:0]);
            CSR_DEW_OFFSET: dew_offset_ff <= $signed(csr_write_data[OFFSET_W-1:0]);
            CSR_RAMP_BAND:  ramp_ff       <= csr_write_data[RAMP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // decision
   always_comb begin
      mode_eff    = latch_ff ? MODE_OFF : mode_req_ff;
      t_ok        = req_ff.temp_valid && (req_ff.heater_temp >= COLD_LIMIT);
      missing     = ((mode_eff == MODE_DEW) || (mode_eff == MODE_TARGET)) &&
                    (!t_ok || ((mode_eff == MODE_DEW) && !req_ff.dew_valid));
      temp_x      = (TEMP_W+1)'(req_ff.heater_temp);
      if (mode_eff == MODE_TARGET) begin
         target_sel = (TEMP_W+1)'(target_ff);
      end else begin
         target_sel = (TEMP_W+1)'(req_ff.dew_point) + (TEMP_W+1)'(dew_offset_ff);
      end
      err_full    = (TEMP_W+2)'(target_sel) - (TEMP_W+2)'(temp_x);
      err_in      = err_full[ERR_W-1:0];
      span_neg_in = min_duty_ff > max_duty_ff;
      span_mag_in = span_neg_in ? (min_duty_ff - max_duty_ff)
                                : (max_duty_ff - min_duty_ff);
      mode_now_in = missing ? MODE_OFF : mode_eff;
      latch_in    = latch_ff | missing;
      if (mode_eff == MODE_FIXED) begin
         kind_in = LVL_MAX;
      end else if (mode_eff == MODE_OFF || missing || temp_x >= target_sel) begin
         kind_in = LVL_ZERO;
      end else if (ramp_ff == '0) begin
         kind_in = LVL_MAX;
      end else begin
         kind_in = LVL_RAMP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         latch_ff <= 1'b0;
      end else if (csr_write_en && csr_index == CSR_MODE) begin
         latch_ff <= 1'b0;
      end else if (cmd.prep) begin
         latch_ff <= latch_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_data;
      end
      if (cmd.prep) begin
         kind_ff     <= kind_in;
         mode_now_ff <= mode_now_in;
         err_ff      <= err_in;
         span_neg_ff <= span_neg_in;
         span_mag_ff <= span_mag_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
   end

   // multiply, then restoring divide one quotient bit per cycle
   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      shifted = {rem_ff, quot_ff[PROD_W-1]};
      if (cmd.mult) begin
         quot_in = PROD_W'(err_ff) * PROD_W'(span_mag_ff);
         rem_in  = '0;
      end else if (cmd.div_step) begin
         if (shifted >= {1'b0, ramp_ff}) begin
            rem_in  = RAMP_W'(shifted - {1'b0, ramp_ff});
            quot_in = {quot_ff[PROD_W-2:0], 1'b1};
         end else begin
            rem_in  = shifted[RAMP_W-1:0];
            quot_in = {quot_ff[PROD_W-2:0], 1'b0};
         end
      end
   end

   // level and clamp
   always_comb begin
      q_signed = $signed({2'b00, quot_ff});
      if (span_neg_ff) begin
         q_signed = -q_signed;
      end
      sum = $signed({{(PROD_W+2-DUTY_W){1'b0}}, min_duty_ff}) + q_signed;
      if (sum < 0) begin
         ramp_level = '0;
      end else if (sum > $signed((PROD_W+2)'(255))) begin
         ramp_level = '1;
      end else begin
         ramp_level = sum[DUTY_W-1:0];
      end
      case (kind_ff)
         LVL_ZERO: level = '0;
         LVL_MAX:  level = max_duty_ff;
         LVL_RAMP: level = ramp_level;
         default:  level = '0;
      endcase
      rsp_in.pwm_level   = level;
      rsp_in.pwm_changed = level != last_level_ff;
      rsp_in.mode_now    = mode_now_ff;
      rsp_in.forced_off  = latch_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         last_level_ff <= '0;
      end else if (cmd.out_load) begin
         rsp_valid_ff  <= 1'b1;
         last_level_ff <= level;
      end else if (!rsp_stall) begin
         rsp_valid_ff  <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign status.out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_ff;

endmodule

FILE: rtl/heater_duty_controller_top.sv
// Heater duty controller top level: sequencer plus datapath.
// Depends on hdc_pkg, hdc_ctrl and hdc_dp.
//
// Usage:
//   csr_*: plain write port, one register per cycle with csr_write_en high.
//     Index 0 mode, 1 max duty, 2 min duty, 3 target temperature,
//     4 dewpoint offset, 5 ramp band; other indexes are ignored. Writing
//     the mode register clears a sensor-loss off latch. Write only while
//     the block is idle.
//   req_*: one sensor request per control tick, taken when req_valid is
//     high and req_stall low. req_stall stays high while a request is
//     being worked on.
//   rsp_*: one result per request, held in an output register until taken
//     (rsp_valid high, rsp_stall low).
// Sequence: after the accepting edge come decision, multiply, the
// bit-serial divider and the result load, which sets rsp_valid.
// The next request is taken only after the result load.
// A new request is taken while the previous result is still waiting; if
// the receiver stalls, the next result waits in the sequencer until the
// output register frees up.
// Reset (synchronous): control registers, last level and off latch cleared.
module heater_duty_controller_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_en,
   input  logic [hdc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [hdc_pkg::CSR_DATA_W-1:0] csr_write_data,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  hdc_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output hdc_pkg::rsp_type               rsp_data
);
   import hdc_pkg::*;

   cmd_type    cmd;
   status_type status;

   hdc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   hdc_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .cmd            (cmd),
      .status         (status)
   );

endmodule
